[src/ordered_key_value_table_macros.svh]
// assertion macros shared by the checker
`ifndef ORDERED_KEY_VALUE_TABLE_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define OKVT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("okvt check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define OKVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("okvt check failed");

`endif

[src/okvt_pkg.sv]
`default_nettype none

package okvt_pkg;

  // build defaults
  localparam int DEPTH_DEF      = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths of the ports
  localparam int FIELD_W = 32;
  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 3'd1;
  localparam logic [OP_W-1:0] OP_UPSERT  = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE   = 3'd3;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd4;
  localparam logic [OP_W-1:0] OP_READPOS = 3'd5;

  // commands broadcast to the cell row
  typedef struct packed {
    logic shift;
    logic append;
    logic update;
  } okvt_cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } okvt_state_t;

endpackage

`default_nettype wire

[src/okvt_cell.sv]
`default_nettype none

module okvt_cell #(
  parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  wire                    clk,
  input  okvt_pkg::okvt_cmd_t    cmd,
  input  wire  [CNT_W-1:0]       count,
  input  wire  [KEY_BITS-1:0]    req_key,
  input  wire  [VALUE_BITS-1:0]  req_value,
  input  wire  [IDX_W-1:0]       hit_idx,
  input  wire  [IDX_W-1:0]       pos_idx,
  input  wire  [KEY_BITS-1:0]    nb_key,
  input  wire  [VALUE_BITS-1:0]  nb_value,
  output logic [KEY_BITS-1:0]    stored_key,
  output logic [VALUE_BITS-1:0]  stored_value,
  output logic                   hit,
  output logic [VALUE_BITS-1:0]  hit_value,
  output logic [KEY_BITS-1:0]    pos_key,
  output logic [VALUE_BITS-1:0]  pos_value
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic live;
  logic pos_sel;

  // key compare against the request, live entries only
  assign live      = MY_CNT < count;
  assign hit       = live && (stored_key == req_key);
  assign hit_value = hit ? stored_value : '0;

  // read by position
  assign pos_sel   = (MY_IDX == pos_idx);
  assign pos_key   = pos_sel ? stored_key : '0;
  assign pos_value = pos_sel ? stored_value : '0;

  // shift down from the neighbor, append at the tail, or overwrite the value
  always_ff @(posedge clk) begin
    priority if (cmd.shift && (MY_IDX >= hit_idx)) begin
      stored_key   <= nb_key;
      stored_value <= nb_value;
    end else if (cmd.append && (MY_CNT == count)) begin
      stored_key   <= req_key;
      stored_value <= req_value;
    end else if (cmd.update && hit) begin
      stored_value <= req_value;
    end else begin
      // hold
      stored_key   <= stored_key;
      stored_value <= stored_value;
    end
  end

endmodule

`default_nettype wire

[src/okvt_select.sv]
`default_nettype none

module okvt_select #(
  parameter int DEPTH      = okvt_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF,
  parameter int IDX_W      = 6
) (
  input  wire  [DEPTH-1:0]       hit,
  input  wire  [VALUE_BITS-1:0]  hit_value [DEPTH],
  input  wire  [KEY_BITS-1:0]    pos_key   [DEPTH],
  input  wire  [VALUE_BITS-1:0]  pos_value [DEPTH],
  output logic                   any_hit,
  output logic [IDX_W-1:0]       hit_idx,
  output logic [VALUE_BITS-1:0]  sel_hit_value,
  output logic [KEY_BITS-1:0]    sel_pos_key,
  output logic [VALUE_BITS-1:0]  sel_pos_value
);

  // keys are unique, so at most one cell hits: or the masked outputs together
  always_comb begin
    any_hit       = |hit;
    hit_idx       = '0;
    sel_hit_value = '0;
    sel_pos_key   = '0;
    sel_pos_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_idx       = hit_idx | (hit[i] ? IDX_W'(i) : '0);
      sel_hit_value = sel_hit_value | hit_value[i];
      sel_pos_key   = sel_pos_key | pos_key[i];
      sel_pos_value = sel_pos_value | pos_value[i];
    end
  end

endmodule

`default_nettype wire

[src/ordered_key_value_table.sv]
// flow: a request is registered, then executed, and its result is registered
//   once the output can take it; one request at a time, by a single compare and
//   update pass through the cell row (all cells compare at once, erase shifts)
// reset: entry count clears to zero and the capacity register returns to 64;
//   the key and value cells are not cleared, only live entries are read
`default_nettype none

module ordered_key_value_table #(
  parameter int DEPTH      = okvt_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               config_we,
  input  wire  [okvt_pkg::COUNT_W-1:0]      config_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [okvt_pkg::OP_W-1:0]         operation,
  input  wire  [okvt_pkg::FIELD_W-1:0]      key,
  input  wire  [okvt_pkg::FIELD_W-1:0]      value_in,
  input  wire  [okvt_pkg::POS_W-1:0]        position,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              success,
  output logic [okvt_pkg::FIELD_W-1:0]      found_key,
  output logic [okvt_pkg::FIELD_W-1:0]      found_value,
  output logic [okvt_pkg::COUNT_W-1:0]      entry_count,
  output logic                              is_empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int FW    = okvt_pkg::FIELD_W;
  localparam int KEXT  = (KEY_BITS > FW) ? KEY_BITS : FW;
  localparam int VEXT  = (VALUE_BITS > FW) ? VALUE_BITS : FW;
  localparam int PW    = (CNT_W > okvt_pkg::POS_W) ? CNT_W : okvt_pkg::POS_W;
  localparam int PIW   = (IDX_W > okvt_pkg::POS_W) ? IDX_W : okvt_pkg::POS_W;
  localparam int CW    = (CNT_W > okvt_pkg::COUNT_W) ? CNT_W : okvt_pkg::COUNT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  okvt_pkg::okvt_state_t state, state_next;

  logic [okvt_pkg::COUNT_W-1:0] cap;
  logic [CNT_W-1:0]             count, count_next;
  logic [okvt_pkg::OP_W-1:0]    req_op;
  logic [KEY_BITS-1:0]          req_key;
  logic [VALUE_BITS-1:0]        req_value;
  logic [okvt_pkg::POS_W-1:0]   req_pos;

  logic [KEXT-1:0] key_wide;
  logic [VEXT-1:0] value_wide;
  logic [PIW-1:0]  pos_wide;
  logic [IDX_W-1:0] pos_idx;

  logic                  fire;
  logic                  full;
  logic                  pos_ok;
  logic                  ok;
  logic [KEY_BITS-1:0]   okey;
  logic [VALUE_BITS-1:0] oval;
  logic [KEXT-1:0]       okey_wide;
  logic [VEXT-1:0]       oval_wide;
  logic [CW-1:0]         count_wide;
  okvt_pkg::okvt_cmd_t   cmd, cmd_exec;

  logic [DEPTH-1:0]      hit;
  logic [KEY_BITS-1:0]   cell_key   [DEPTH];
  logic [VALUE_BITS-1:0] cell_value [DEPTH];
  logic [VALUE_BITS-1:0] hit_value  [DEPTH];
  logic [KEY_BITS-1:0]   pos_key    [DEPTH];
  logic [VALUE_BITS-1:0] pos_value  [DEPTH];
  logic                  any_hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [VALUE_BITS-1:0] sel_hit_value;
  logic [KEY_BITS-1:0]   sel_pos_key;
  logic [VALUE_BITS-1:0] sel_pos_value;

  // handshake
  assign in_ready = (state == okvt_pkg::ST_IDLE);
  assign fire     = (state == okvt_pkg::ST_EXEC) && (!out_valid || out_ready);

  // request fields masked to the built widths
  assign key_wide   = KEXT'(key);
  assign value_wide = VEXT'(value_in);
  assign pos_wide   = PIW'(req_pos);
  assign pos_idx    = pos_wide[IDX_W-1:0];

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= okvt_pkg::CAP_RESET;
    end else if (config_we) begin
      cap <= config_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op    <= operation;
      req_key   <= key_wide[KEY_BITS-1:0];
      req_value <= value_wide[VALUE_BITS-1:0];
      req_pos   <= position;
    end
  end

  // cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0]   nb_key;
    logic [VALUE_BITS-1:0] nb_value;
    if (g == DEPTH - 1) begin : g_last
      assign nb_key   = cell_key[g];
      assign nb_value = cell_value[g];
    end else begin : g_mid
      assign nb_key   = cell_key[g+1];
      assign nb_value = cell_value[g+1];
    end
    okvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .INDEX      (g)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .count        (count),
      .req_key      (req_key),
      .req_value    (req_value),
      .hit_idx      (hit_idx),
      .pos_idx      (pos_idx),
      .nb_key       (nb_key),
      .nb_value     (nb_value),
      .stored_key   (cell_key[g]),
      .stored_value (cell_value[g]),
      .hit          (hit[g]),
      .hit_value    (hit_value[g]),
      .pos_key      (pos_key[g]),
      .pos_value    (pos_value[g])
    );
  end

  // gather the hit and position results
  okvt_select #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_select (
    .hit           (hit),
    .hit_value     (hit_value),
    .pos_key       (pos_key),
    .pos_value     (pos_value),
    .any_hit       (any_hit),
    .hit_idx       (hit_idx),
    .sel_hit_value (sel_hit_value),
    .sel_pos_key   (sel_pos_key),
    .sel_pos_value (sel_pos_value)
  );

  // table full and position range checks
  assign full   = (CW'(count) >= CW'(cap)) || (count == FULL_CNT);
  assign pos_ok = PW'(req_pos) < PW'(count);

  // operation decode
  always_comb begin
    ok       = 1'b0;
    okey     = req_key;
    oval     = '0;
    cmd_exec = '0;
    unique case (req_op)
      okvt_pkg::OP_INSERT: begin
        ok              = !any_hit && !full;
        cmd_exec.append = ok;
      end
      okvt_pkg::OP_UPDATE: begin
        ok              = any_hit;
        cmd_exec.update = any_hit;
      end
      okvt_pkg::OP_UPSERT: begin
        ok              = any_hit || !full;
        cmd_exec.update = any_hit;
        cmd_exec.append = !any_hit && !full;
      end
      okvt_pkg::OP_ERASE: begin
        ok             = any_hit;
        cmd_exec.shift = any_hit;
      end
      okvt_pkg::OP_LOOKUP: begin
        ok   = any_hit;
        oval = any_hit ? sel_hit_value : '0;
      end
      okvt_pkg::OP_READPOS: begin
        ok = pos_ok;
        if (pos_ok) begin
          okey = sel_pos_key;
          oval = sel_pos_value;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // commands only take effect on the completing cycle
  assign cmd = fire ? cmd_exec : '0;

  // entry count
  always_comb begin
    count_next = count;
    priority if (cmd.append) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.shift) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  // state sequence
  always_comb begin
    state_next = state;
    unique case (state)
      okvt_pkg::ST_IDLE: if (in_valid) state_next = okvt_pkg::ST_EXEC;
      okvt_pkg::ST_EXEC: if (fire) state_next = okvt_pkg::ST_IDLE;
      default: state_next = okvt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= okvt_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  assign okey_wide  = KEXT'(okey);
  assign oval_wide  = VEXT'(oval);
  assign count_wide = CW'(count_next);

  always_ff @(posedge clk) begin
    if (fire) begin
      success     <= ok;
      found_key   <= okey_wide[FW-1:0];
      found_value <= oval_wide[FW-1:0];
      entry_count <= count_wide[okvt_pkg::COUNT_W-1:0];
      is_empty    <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire

[src/okvt_checker.sv]
`default_nettype none
`include "ordered_key_value_table_macros.svh"

module okvt_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          success,
  input wire [okvt_pkg::FIELD_W-1:0]  found_value,
  input wire [okvt_pkg::COUNT_W-1:0]  entry_count,
  input wire                          is_empty
);

  // a stalled result holds
  `OKVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found_value))

  // empty flag agrees with the count
  `OKVT_ASSERT_SAME(a_empty_flag, out_valid, is_empty == (entry_count == '0))

  // a failed request never reports a value
  `OKVT_ASSERT_SAME(a_fail_zero, out_valid && !success, found_value == '0)

  // one request at a time: busy in the cycle after a request is taken
  `OKVT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (.*);

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int OP_W      = okvt_pkg::OP_W;
  localparam int FIELD_W   = okvt_pkg::FIELD_W;
  localparam int POS_W     = okvt_pkg::POS_W;
  localparam int COUNT_W   = okvt_pkg::COUNT_W;
  localparam int DEPTH_DEF = okvt_pkg::DEPTH_DEF;

  // codes the block does not implement, expected to do nothing and fail
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 190;
  localparam int POOL_SIZE    = 72;
  localparam int STALL_LIMIT  = 1000;
  localparam int IDLE_PERCENT = 35;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] val;
    logic [POS_W-1:0]   pos;
  } table_req_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] val;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } table_rsp_t;

  logic               clk;
  logic               rst         = 1'b1;
  logic               config_we   = 1'b0;
  logic [COUNT_W-1:0] config_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    operation   = okvt_pkg::OP_INSERT;
  logic [FIELD_W-1:0] key         = '0;
  logic [FIELD_W-1:0] value_in    = '0;
  logic [POS_W-1:0]   position    = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               success;
  logic [FIELD_W-1:0] found_key;
  logic [FIELD_W-1:0] found_value;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;

  ordered_key_value_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .config_we   (config_we),
    .config_data (config_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .key         (key),
    .value_in    (value_in),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .success     (success),
    .found_key   (found_key),
    .found_value (found_value),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

  // shadow copy of the table contents and its capacity register
  logic [FIELD_W-1:0] tbl_keys [DEPTH_DEF];
  logic [FIELD_W-1:0] tbl_vals [DEPTH_DEF];
  int                 tbl_count = 0;
  int                 tbl_cap   = okvt_pkg::CAP_RESET;

  table_req_t pending_requests [$];
  table_rsp_t replies_due [$];
  table_req_t cur_request;
  table_rsp_t got_reply;
  table_rsp_t want_reply;

  logic [FIELD_W-1:0] key_pool [POOL_SIZE];
  logic [OP_W-1:0]    op_menu [7] = '{okvt_pkg::OP_INSERT, okvt_pkg::OP_UPDATE,
                                      okvt_pkg::OP_UPSERT, okvt_pkg::OP_ERASE,
                                      okvt_pkg::OP_LOOKUP, okvt_pkg::OP_READPOS,
                                      OP_RSVD6};
  int phase_cap [NUM_PHASES]   = '{64, 127, 3, 0, 1, 20, 8, 2, 40, 64};
  bit phase_drain [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0, 0, 1};

  bit steady         = 1'b0;
  int mismatches     = 0;
  int requests_sent  = 0;
  int replies_seen   = 0;
  int cap_settings   = 0;
  int peak_count     = 0;
  int full_refusals  = 0;
  int idle_cycles    = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // index of the live entry holding k, or -1
  function automatic int find_live(input logic [FIELD_W-1:0] k);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // append at the tail when there is room under the capacity
  function automatic bit append_entry(input logic [FIELD_W-1:0] k,
                                      input logic [FIELD_W-1:0] v);
    int room;
    room = (tbl_cap > DEPTH_DEF) ? DEPTH_DEF : tbl_cap;
    if (tbl_count >= room) begin
      full_refusals++;
      return 1'b0;
    end
    tbl_keys[tbl_count] = k;
    tbl_vals[tbl_count] = v;
    tbl_count++;
    if (tbl_count > peak_count) peak_count = tbl_count;
    return 1'b1;
  endfunction

  // apply one request to the shadow table and return its reply
  function automatic table_rsp_t table_apply(input table_req_t r);
    int hit;
    table_rsp_t rsp;
    rsp.ok  = 1'b0;
    rsp.key = r.key;
    rsp.val = '0;
    hit = find_live(r.key);
    case (r.op)
      okvt_pkg::OP_INSERT: begin
        if (hit < 0) rsp.ok = append_entry(r.key, r.val);
      end
      okvt_pkg::OP_UPDATE, okvt_pkg::OP_UPSERT: begin
        if (hit >= 0) begin
          tbl_vals[hit] = r.val;
          rsp.ok = 1'b1;
        end else if (r.op == okvt_pkg::OP_UPSERT) begin
          rsp.ok = append_entry(r.key, r.val);
        end
      end
      okvt_pkg::OP_ERASE: begin
        if (hit >= 0) begin
          // later entries slide down one place
          for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i + 1];
            tbl_vals[i] = tbl_vals[i + 1];
          end
          tbl_count--;
          rsp.ok = 1'b1;
        end
      end
      okvt_pkg::OP_LOOKUP: begin
        if (hit >= 0) begin
          rsp.val = tbl_vals[hit];
          rsp.ok  = 1'b1;
        end
      end
      okvt_pkg::OP_READPOS: begin
        if (int'(r.pos) < tbl_count) begin
          rsp.key = tbl_keys[r.pos];
          rsp.val = tbl_vals[r.pos];
          rsp.ok  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp.count = COUNT_W'(tbl_count);
    rsp.empty = (tbl_count == 0);
    return rsp;
  endfunction

  // random request with content drawn mostly from a shared key pool
  function automatic table_req_t make_request(input int pool_n, input bit drain);
    int weights [7];
    int roll;
    int acc;
    int pick;
    table_req_t r;
    if (drain) weights = '{10, 10, 3, 45, 15, 15, 2};
    else weights = '{28, 12, 18, 14, 14, 12, 2};
    roll = $urandom_range(99);
    acc  = 0;
    for (pick = 0; pick < 6; pick++) begin
      acc += weights[pick];
      if (roll < acc) break;
    end
    r.op = op_menu[pick];
    if (r.op == OP_RSVD6 && $urandom_range(1) == 1) r.op = OP_RSVD7;
    r.key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1)];
    r.val = $urandom;
    r.pos = ($urandom_range(1) == 0) ? POS_W'($urandom_range(7)) : POS_W'($urandom);
    return r;
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] k,
                               input logic [FIELD_W-1:0] v, input logic [POS_W-1:0] p);
    table_req_t r;
    r.op  = op;
    r.key = k;
    r.val = v;
    r.pos = p;
    pending_requests.push_back(r);
  endtask

  // hold off until every request is answered and the block is quiet
  task automatic settle();
    while (pending_requests.size() != 0 || in_valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] cap);
    @(posedge clk);
    config_we   <= 1'b1;
    config_data <= cap;
    @(posedge clk);
    config_we <= 1'b0;
    tbl_cap = cap;
    cap_settings++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      replies_due.push_back(table_apply(cur_request));
      requests_sent++;
    end
    if (!in_valid || in_ready) begin
      if (pending_requests.size() != 0 &&
          (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
        cur_request = pending_requests.pop_front();
        operation <= cur_request.op;
        key       <= cur_request.key;
        value_in  <= cur_request.val;
        position  <= cur_request.pos;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // reply monitor and checker
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    if (!rst && out_valid && out_ready) begin
      replies_seen++;
      got_reply.ok    = success;
      got_reply.key   = found_key;
      got_reply.val   = found_value;
      got_reply.count = entry_count;
      got_reply.empty = is_empty;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: ok=%0b key=%h val=%h count=%0d empty=%0b",
                   got_reply.ok, got_reply.key, got_reply.val, got_reply.count,
                   got_reply.empty);
      end else begin
        want_reply = replies_due.pop_front();
        if (got_reply !== want_reply) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"reply mismatch: want ok=%0b key=%h val=%h count=%0d empty=%0b,",
                      " got ok=%0b key=%h val=%h count=%0d empty=%0b"},
                     want_reply.ok, want_reply.key, want_reply.val, want_reply.count,
                     want_reply.empty, got_reply.ok, got_reply.key, got_reply.val,
                     got_reply.count, got_reply.empty);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int pool_n;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table misses, field extremes, duplicates, shifts, bad codes
    queue_request(okvt_pkg::OP_LOOKUP,  32'h0,        32'h0,        6'd0);
    queue_request(okvt_pkg::OP_READPOS, 32'h0,        32'h0,        6'd0);
    queue_request(okvt_pkg::OP_ERASE,   32'hFFFFFFFF, 32'h0,        6'd0);
    queue_request(okvt_pkg::OP_UPDATE,  32'h0,        32'h1,        6'd0);
    queue_request(okvt_pkg::OP_INSERT,  32'h0,        32'hFFFFFFFF, 6'd0);
    queue_request(okvt_pkg::OP_INSERT,  32'hFFFFFFFF, 32'h0,        6'd63);
    queue_request(okvt_pkg::OP_INSERT,  32'h0,        32'h1,        6'd0);
    queue_request(okvt_pkg::OP_UPSERT,  32'hFFFFFFFF, 32'h12345678, 6'd0);
    queue_request(okvt_pkg::OP_UPSERT,  32'h5,        32'hA5A5A5A5, 6'd0);
    queue_request(okvt_pkg::OP_UPDATE,  32'h0,        32'h5A5A5A5A, 6'd0);
    queue_request(okvt_pkg::OP_LOOKUP,  32'hFFFFFFFF, 32'h0,        6'd0);
    queue_request(okvt_pkg::OP_READPOS, 32'h0,        32'h0,        6'd0);
    queue_request(okvt_pkg::OP_READPOS, 32'h0,        32'h0,        6'd2);
    queue_request(okvt_pkg::OP_READPOS, 32'h0,        32'h0,        6'd3);
    queue_request(okvt_pkg::OP_READPOS, 32'hFFFFFFFF, 32'h0,        6'd63);
    queue_request(okvt_pkg::OP_ERASE,   32'h0,        32'h0,        6'd0);
    queue_request(okvt_pkg::OP_READPOS, 32'h0,        32'h0,        6'd0);
    queue_request(okvt_pkg::OP_READPOS, 32'h0,        32'h0,        6'd1);
    queue_request(OP_RSVD6,             32'h5,        32'hFFFFFFFF, 6'd63);
    queue_request(OP_RSVD7,             32'hFFFFFFFF, 32'hFFFFFFFF, 6'd0);
    queue_request(okvt_pkg::OP_ERASE,   32'h5,        32'h0,        6'd0);
    queue_request(okvt_pkg::OP_ERASE,   32'hFFFFFFFF, 32'h0,        6'd0);
    queue_request(okvt_pkg::OP_LOOKUP,  32'hFFFFFFFF, 32'h0,        6'd0);
    settle();

    // random phases, each at its own capacity, with the sender drained in between
    phase_cap[5] = $urandom_range(1, DEPTH_DEF);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(COUNT_W'(phase_cap[p]));
      steady = (p == 0);
      if (phase_drain[p] || phase_cap[p] + 6 > POOL_SIZE) pool_n = POOL_SIZE;
      else pool_n = phase_cap[p] + 6;
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_requests.push_back(make_request(pool_n, phase_drain[p]));
      settle();
    end

    $display("run covered %0d requests and %0d replies over %0d capacity settings",
             requests_sent, replies_seen, cap_settings);
    $display("peak occupancy %0d, inserts refused for room %0d, mismatches %0d",
             peak_count, full_refusals, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
